// ===== rtl/multicast_vc_reservation_table_defines.svh =====
// Assertion macros shared by the reservation table.
`ifndef MULTICAST_VC_RESERVATION_TABLE_DEFINES_SVH
`define MULTICAST_VC_RESERVATION_TABLE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MVRT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define MVRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/mvrt_pkg.sv =====
package mvrt_pkg;
    localparam int NUM_OUTPUTS = 8;
    localparam int NUM_INPUTS  = 8;
    localparam int NUM_VCS     = 4;
    localparam int SLOT_W      = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
    localparam int COUNT_W     = $clog2(NUM_VCS + 1);
    localparam int PAIR_W      = 5;

    typedef logic [2:0] req_t;
    localparam req_t REQ_RESERVE = 3'd0;
    localparam req_t REQ_CHECK   = 3'd1;
    localparam req_t REQ_RELEASE = 3'd2;
    localparam req_t REQ_LOOKUP  = 3'd3;
    localparam req_t REQ_TICK    = 3'd4;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_SAME    = 3'd1;
    localparam status_t ST_BUSY    = 3'd2;
    localparam status_t ST_OTHER   = 3'd3;
    localparam status_t ST_MISSING = 3'd4;

    typedef logic [PAIR_W-1:0] pair_t;

    // What one lane reports about the pair during the scan cycle.
    typedef struct packed {
        logic held;
        logic vc_clash;
        logic busy;
    } lane_scan_t;

    // Command from the merge stage to every lane.
    typedef struct packed {
        logic  do_append;
        logic  do_release;
        logic  do_tick;
        logic  selected;
        pair_t pair;
    } lane_cmd_t;

    typedef enum logic [1:0] {P_IDLE, P_UPDATE, P_RESULT} phase_t;
endpackage

// ===== rtl/mvrt_if.sv =====
interface mvrt_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [2:0] in_port;
    logic [1:0] vc;
    logic [7:0] out_mask;
    modport source (output valid, req_type, in_port, vc, out_mask, input ready);
    modport sink (input valid, req_type, in_port, vc, out_mask, output ready);
endinterface

interface mvrt_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] held_mask;
    logic [7:0] busy_mask;
    modport source (output valid, status, held_mask, busy_mask, input ready);
    modport sink (input valid, status, held_mask, busy_mask, output ready);
endinterface

// ===== rtl/multicast_vc_reservation_table.sv =====
// Multicast virtual-channel reservation table for a switch's outputs.
// Requests arrive on req (req_type, in_port, vc, out_mask); every request
// transaction returns exactly one response transaction on rsp carrying the
// status, the outputs holding the (in_port, vc) pair and the busy outputs,
// both taken after the request's update.
// Each output is a lane with its own list, count and rotating index; all
// lanes compare the pair in parallel and a merge stage forms the check
// outcome and drives the per-lane update.
// Timing: the request is captured, the lanes update in the next cycle,
// and the response is registered on the cycle after that. One request is
// handled at a time and a new one is taken only after the response is
// taken.
// Reset clears all counts and indices; list slots are only read below the
// count, so they need no clearing. When the receiver stalls, the response
// register holds its value and no new request is taken until it is taken.
module multicast_vc_reservation_table (
    input logic clk,
    input logic rst_n,
    mvrt_req_if.sink   req,
    mvrt_rsp_if.source rsp
);
    import mvrt_pkg::*;
    `include "multicast_vc_reservation_table_defines.svh"

    phase_t                 phase_reg, phase_next;
    req_t                   type_reg;
    pair_t                  pair_reg;
    logic [NUM_OUTPUTS-1:0] sel_reg;
    logic                   missing_reg;
    status_t                outcome_reg;
    logic                   rsp_valid_reg;
    status_t                status_reg;
    logic [7:0]             held_reg, busy_reg;

    lane_scan_t             scan [NUM_OUTPUTS];
    lane_cmd_t              cmd [NUM_OUTPUTS];
    logic [NUM_OUTPUTS-1:0] missing;
    status_t                outcome;
    logic                   req_fire;
    logic [7:0]             held_now, busy_now;

    assign req.ready = (phase_reg == P_IDLE) && !rsp_valid_reg;
    assign req_fire  = req.valid && req.ready;

    for (genvar o = 0; o < NUM_OUTPUTS; o++)
    begin : g_lane
        mvrt_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .scan_pair (pair_reg),
            .cmd       (cmd[o]),
            .scan      (scan[o]),
            .missing   (missing[o])
        );
    end

    mvrt_merge u_merge (
        .req_type (type_reg),
        .pair     (pair_reg),
        .sel      (sel_reg),
        .update   (phase_reg == P_UPDATE),
        .scan     (scan),
        .cmd      (cmd),
        .outcome  (outcome)
    );

    // Gather the per-lane flags into the response masks.
    always_comb
    begin
        held_now = '0;
        busy_now = '0;
        for (int o = 0; o < NUM_OUTPUTS; o++)
        begin
            held_now[o] = scan[o].held;
            busy_now[o] = scan[o].busy;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            P_IDLE:   if (req_fire) phase_next = P_UPDATE;
            P_UPDATE: phase_next = P_RESULT;
            P_RESULT: phase_next = P_IDLE;
            default:  phase_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (phase_reg == P_RESULT)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            type_reg <= req.req_type;
            pair_reg <= {req.in_port, req.vc};
            sel_reg  <= req.out_mask[NUM_OUTPUTS-1:0];
        end
        if (phase_reg == P_UPDATE)
        begin
            missing_reg <= (missing != '0);
            outcome_reg <= outcome;
        end
        if (phase_reg == P_RESULT)
        begin
            held_reg <= held_now;
            busy_reg <= busy_now;
            if (type_reg == REQ_RESERVE || type_reg == REQ_CHECK)
                status_reg <= outcome_reg;
            else if (type_reg == REQ_RELEASE && missing_reg)
                status_reg <= ST_MISSING;
            else
                status_reg <= ST_OK;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.held_mask = held_reg;
    assign rsp.busy_mask = busy_reg;

    `MVRT_ASSERT_NEXT(a_accept_to_update, req_fire, phase_reg == P_UPDATE)
    `MVRT_ASSERT_IMPL(a_no_accept_while_pending, rsp_valid_reg, !req.ready)
    `MVRT_ASSERT_NEXT(a_result_raises_valid, phase_reg == P_RESULT, rsp_valid_reg)
endmodule

// ===== rtl/mvrt_lane.sv =====
// One output port's reservation list, rotating index and count.
module mvrt_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  mvrt_pkg::pair_t     scan_pair,
    input  mvrt_pkg::lane_cmd_t cmd,
    output mvrt_pkg::lane_scan_t scan,
    output logic                missing
);
    import mvrt_pkg::*;

    pair_t              slot_reg [NUM_VCS];
    logic [COUNT_W-1:0] count_reg;
    logic [SLOT_W-1:0]  index_reg;

    logic [NUM_VCS-1:0] hit;
    logic [SLOT_W-1:0]  hit_pos;
    logic               found;
    logic [COUNT_W-1:0] count_dec;

    always_comb
    begin
        hit     = '0;
        hit_pos = '0;
        found   = 1'b0;
        scan.vc_clash = 1'b0;
        for (int i = 0; i < NUM_VCS; i++)
        begin
            if (COUNT_W'(i) < count_reg)
            begin
                hit[i] = (slot_reg[i] == scan_pair);
                if (slot_reg[i][PAIR_W-1:2] != scan_pair[PAIR_W-1:2] &&
                    slot_reg[i][1:0] == scan_pair[1:0])
                    scan.vc_clash = 1'b1;
            end
        end
        for (int i = NUM_VCS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_pos = SLOT_W'(i);
                found   = 1'b1;
            end
        end
        scan.held = found;
        scan.busy = (count_reg != '0);
        count_dec = count_reg - COUNT_W'(1);
        missing   = cmd.do_release && cmd.selected && !found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            index_reg <= '0;
        end
        else if (cmd.do_append && cmd.selected && count_reg < COUNT_W'(NUM_VCS))
        begin
            count_reg <= count_reg + COUNT_W'(1);
        end
        else if (cmd.do_release && cmd.selected && found)
        begin
            count_reg <= count_dec;
            if (hit_pos < index_reg)
                index_reg <= index_reg - SLOT_W'(1);
            else if (COUNT_W'(index_reg) >= count_dec)
                index_reg <= '0;
        end
        else if (cmd.do_tick && count_reg != '0)
        begin
            if (COUNT_W'(index_reg) + COUNT_W'(1) >= count_reg)
                index_reg <= '0;
            else
                index_reg <= index_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_append && cmd.selected && count_reg < COUNT_W'(NUM_VCS))
            slot_reg[count_reg[SLOT_W-1:0]] <= cmd.pair;
        else if (cmd.do_release && cmd.selected && found)
        begin
            for (int i = 0; i < NUM_VCS - 1; i++)
                if (SLOT_W'(i) >= hit_pos)
                    slot_reg[i] <= slot_reg[i+1];
        end
    end
endmodule

// ===== rtl/mvrt_merge.sv =====
// Combines the lane reports into the check outcome and the lane commands.
module mvrt_merge (
    input  mvrt_pkg::req_t     req_type,
    input  mvrt_pkg::pair_t    pair,
    input  logic [mvrt_pkg::NUM_OUTPUTS-1:0] sel,
    input  logic               update,
    input  mvrt_pkg::lane_scan_t scan [mvrt_pkg::NUM_OUTPUTS],
    output mvrt_pkg::lane_cmd_t  cmd [mvrt_pkg::NUM_OUTPUTS],
    output mvrt_pkg::status_t    outcome
);
    import mvrt_pkg::*;

    logic [NUM_OUTPUTS-1:0] held;
    logic                   clash;

    always_comb
    begin
        clash = 1'b0;
        for (int o = 0; o < NUM_OUTPUTS; o++)
        begin
            held[o] = scan[o].held;
            if (sel[o] && scan[o].vc_clash)
                clash = 1'b1;
        end
        if (held != '0)
            outcome = (held == sel) ? ST_SAME : ST_OTHER;
        else if (clash)
            outcome = ST_BUSY;
        else
            outcome = ST_OK;
        for (int o = 0; o < NUM_OUTPUTS; o++)
        begin
            cmd[o].do_append  = update && req_type == REQ_RESERVE && outcome == ST_OK;
            cmd[o].do_release = update && req_type == REQ_RELEASE;
            cmd[o].do_tick    = update && req_type == REQ_TICK;
            cmd[o].selected   = sel[o];
            cmd[o].pair       = pair;
        end
    end
endmodule
